// ----- rtl/mcc_pkg.sv -----
// mcc_pkg: shared types and constants for the triangle circumcircle curvature block
// depends on nothing
`default_nettype none
package mcc_pkg;

  localparam int unsigned SIDE_BITS         = 32;
  localparam int unsigned CURV_BITS         = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_TRI = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [SIDE_BITS-1:0] side_a;
    logic [SIDE_BITS-1:0] side_b;
    logic [SIDE_BITS-1:0] side_c;
  } side_word_t;

  typedef struct packed {
    logic [CURV_BITS-1:0] circle_curvature;
    status_t              status;
  } curv_word_t;

endpackage
`default_nettype wire

// ----- rtl/triangle_circumcircle_curvature.sv -----
// triangle_circumcircle_curvature: pipelined circumcircle curvature of a triangle
// depends on mcc_pkg
`default_nettype none
// Takes one word of three unsigned fixed-point side lengths per cycle while the
// output is not stalled and returns floor(isqrt(P * 2^(4F)) / (a*b*c)), P the
// product of the four Heron terms, with saturation and a not-a-triangle status.
// Fully pipelined: a new word can enter before earlier results leave. The square
// root settles one root bit per stage of the RW-bit root, RW being half the
// width of the scaled Heron product (four times (SIDE_BITS + 2 + FRACTION_BITS),
// halved), and the divider one quotient bit per stage. A stall at the output
// freezes the whole pipeline.
module triangle_circumcircle_curvature
  import mcc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       side_valid,
  output logic       side_ready,
  input  side_word_t sides,
  output logic       curv_valid,
  input  logic       curv_ready,
  output curv_word_t curv
);

  localparam int unsigned SB = SIDE_BITS;
  localparam int unsigned TW = SB + 2;
  localparam int unsigned PW = 4 * TW;
  localparam int unsigned NW = PW + 4 * FRACTION_BITS;
  localparam int unsigned RW = NW / 2;
  localparam int unsigned DW = 3 * SB;
  localparam int unsigned QW = CURV_BITS;
  localparam int unsigned WW = (RW > DW + QW) ? RW : DW + QW;

  logic advance;
  assign advance    = !curv_valid || curv_ready;
  assign side_ready = advance;

  // stage 1: heron terms and triangle test
  logic [SB:0]   s_ab, s_bc, s_ac;
  logic          bad_now;
  logic          v1, bad1;
  logic [TW-1:0] t1, t2, t3, t4;
  logic [SB-1:0] a1, b1, c1;

  always_comb begin
    s_ab    = (SB+1)'(sides.side_a) + (SB+1)'(sides.side_b);
    s_bc    = (SB+1)'(sides.side_b) + (SB+1)'(sides.side_c);
    s_ac    = (SB+1)'(sides.side_a) + (SB+1)'(sides.side_c);
    bad_now = !((s_ab > (SB+1)'(sides.side_c)) && (s_bc > (SB+1)'(sides.side_a)) &&
                (s_ac > (SB+1)'(sides.side_b)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= side_valid;
    end
    if (advance) begin
      bad1 <= bad_now;
      t1   <= TW'(s_ab) + TW'(sides.side_c);
      t2   <= TW'(s_bc) - TW'(sides.side_a);
      t3   <= TW'(s_ac) - TW'(sides.side_b);
      t4   <= TW'(s_ab) - TW'(sides.side_c);
      a1   <= sides.side_a;
      b1   <= sides.side_b;
      c1   <= sides.side_c;
    end
  end

  // stage 2: pair products
  logic            v2, bad2;
  logic [2*TW-1:0] p12, p34;
  logic [2*SB-1:0] dab;
  logic [SB-1:0]   c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      bad2 <= bad1;
      p12  <= (2*TW)'(t1) * (2*TW)'(t2);
      p34  <= (2*TW)'(t3) * (2*TW)'(t4);
      dab  <= (2*SB)'(a1) * (2*SB)'(b1);
      c2   <= c1;
    end
  end

  // stage 3: partial products
  logic            v3, bad3;
  logic [2*TW-1:0] pp_hh, pp_hl, pp_lh, pp_ll;
  logic [2*SB-1:0] dh, dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
    if (advance) begin
      bad3  <= bad2;
      pp_hh <= (2*TW)'(p12[2*TW-1:TW]) * (2*TW)'(p34[2*TW-1:TW]);
      pp_hl <= (2*TW)'(p12[2*TW-1:TW]) * (2*TW)'(p34[TW-1:0]);
      pp_lh <= (2*TW)'(p12[TW-1:0]) * (2*TW)'(p34[2*TW-1:TW]);
      pp_ll <= (2*TW)'(p12[TW-1:0]) * (2*TW)'(p34[TW-1:0]);
      dh    <= (2*SB)'(dab[2*SB-1:SB]) * (2*SB)'(c2);
      dl    <= (2*SB)'(dab[SB-1:0]) * (2*SB)'(c2);
    end
  end

  // stage 4 and square root pipeline
  logic [NW-1:0] sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];
  logic [DW-1:0] sq_d    [0:RW];
  logic          sq_v    [0:RW];
  logic          sq_bad  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (advance) begin
      sq_v[0] <= v3;
    end
    if (advance) begin
      sq_bad[0]  <= bad3;
      sq_rem[0]  <= (NW'(pp_hh) << (2*TW + 4*FRACTION_BITS)) +
                    ((NW'(pp_hl) + NW'(pp_lh)) << (TW + 4*FRACTION_BITS)) +
                    (NW'(pp_ll) << (4*FRACTION_BITS));
      sq_root[0] <= '0;
      sq_d[0]    <= (DW'(dh) << SB) + DW'(dl);
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int unsigned BIT = RW - 1 - k;
    logic [NW:0] trial;
    assign trial = ((NW+1)'(sq_root[k]) << (BIT + 1)) + ((NW+1)'(1) << (2*BIT));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (advance) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (advance) begin
        sq_bad[k+1] <= sq_bad[k];
        sq_d[k+1]   <= sq_d[k];
        if ((NW+1)'(sq_rem[k]) >= trial) begin
          sq_rem[k+1]  <= NW'((NW+1)'(sq_rem[k]) - trial);
          sq_root[k+1] <= sq_root[k] | (RW'(1) << BIT);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
      end
    end
  end

  // saturation test and divider pipeline
  logic [RW-1:0] dv_rem [0:QW];
  logic [QW-1:0] dv_q   [0:QW];
  logic [DW-1:0] dv_d   [0:QW];
  logic          dv_v   [0:QW];
  logic          dv_bad [0:QW];
  logic          dv_sat [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (advance) begin
      dv_v[0] <= sq_v[RW];
    end
    if (advance) begin
      dv_bad[0] <= sq_bad[RW];
      dv_sat[0] <= (WW'(sq_root[RW]) >= (WW'(sq_d[RW]) << QW));
      dv_rem[0] <= sq_root[RW];
      dv_q[0]   <= '0;
      dv_d[0]   <= sq_d[RW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned BIT = QW - 1 - j;
    logic [WW-1:0] sub;
    assign sub = WW'(dv_d[j]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (advance) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (advance) begin
        dv_bad[j+1] <= dv_bad[j];
        dv_sat[j+1] <= dv_sat[j];
        dv_d[j+1]   <= dv_d[j];
        if (WW'(dv_rem[j]) >= sub) begin
          dv_rem[j+1] <= RW'(WW'(dv_rem[j]) - sub);
          dv_q[j+1]   <= dv_q[j] | (QW'(1) << BIT);
        end else begin
          dv_rem[j+1] <= dv_rem[j];
          dv_q[j+1]   <= dv_q[j];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      curv_valid <= 1'b0;
    end else if (advance) begin
      curv_valid <= dv_v[QW];
    end
    if (advance) begin
      priority if (dv_bad[QW]) begin
        curv.circle_curvature <= '0;
        curv.status           <= ST_NOT_TRI;
      end else if (dv_sat[QW]) begin
        curv.circle_curvature <= '1;
        curv.status           <= ST_SAT;
      end else begin
        curv.circle_curvature <= dv_q[QW];
        curv.status           <= ST_OK;
      end
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    curv_valid && !curv_ready |-> !side_ready)
    else $error("input taken while output stalled");

  a_not_tri_zero: assert property (@(posedge clk) disable iff (rst)
    curv_valid && curv.status == ST_NOT_TRI |-> curv.circle_curvature == '0)
    else $error("not-a-triangle result is nonzero");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    curv_valid && curv.status == ST_SAT |-> curv.circle_curvature == '1)
    else $error("saturated result is not all ones");

  a_zero_side_bad: assert property (@(posedge clk) disable iff (rst)
    v1 && (a1 == '0 || b1 == '0 || c1 == '0) |-> bad1)
    else $error("zero side passed the triangle test");

endmodule
`default_nettype wire
